// ===== src/kmc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package kmc_pkg;

  // Quotient width of every division: Q1.16 features and center means
  localparam int QW = 17;

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_START = 2'd1,
    ACT_QPAT  = 2'd2,
    ACT_QCEN  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_CONV   = 2'd0,
    ST_LIMIT  = 2'd1,
    ST_BADCFG = 2'd2,
    ST_ACK    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CFG_PATTERNS = 2'd0,
    CFG_DIMS     = 2'd1,
    CFG_CLUSTERS = 2'd2,
    CFG_ITERS    = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic [1:0]         action;
    logic [9:0]         pattern_index;
    logic [3:0]         cluster_index;
    logic [3:0]         dim_index;
    logic signed [15:0] raw_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  assigned_cluster;
    logic [16:0] feature_value;
    logic [10:0] member_count;
    logic [13:0] rounds_run;
  } out_item_t;

endpackage
`default_nettype wire

// ===== src/kmeans_cluster_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none
// K-means (Lloyd) clustering engine over a stored feature array.
// Items enter on in_data when start is high and busy is low. Every item
// gives exactly one result on out_data, flagged by out_valid for one cycle,
// in the cycle after the item finishes; the receiver always takes it.
// Load: raw feature written at acceptance, result next cycle, no busy time,
//   so loads can be issued every cycle.
// Query: the memories are read at acceptance, then S_RND_END registers the result.
// Start: busy for the whole run. Normalization divides each feature magnitude
//   by its pattern's magnitude sum (one divider, 17 steps per quotient), then
//   a clear pass zeroes the assignments, centers and member counts, and the
//   first cluster_count patterns seed the centers. Each round computes the
//   pattern-to-center distances through the single squaring unit, then the
//   center update with up to cluster_count*dim_count divisions.
// Reset: busy for a clear pass that zeroes the raw features, assignments,
//   centers and member counts. Configuration writes are taken at any time.
module kmeans_cluster_engine import kmc_pkg::*; #(
  parameter int MAX_PATTERNS = 1024,
  parameter int MAX_DIMS     = 16,
  parameter int MAX_CLUSTERS = 16
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  output logic           busy,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  output out_item_t      out_data,
  input  wire logic      cfg_valid,
  output logic           cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [13:0] cfg_data
);

  localparam int RAWN  = MAX_PATTERNS * MAX_DIMS;
  localparam int CENN  = MAX_CLUSTERS * MAX_DIMS;
  localparam int AW    = $clog2(RAWN);
  localparam int CAW   = $clog2(CENN);
  localparam int PW    = $clog2(MAX_PATTERNS);
  localparam int CLW   = $clog2(MAX_CLUSTERS);
  localparam int DW    = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int CNTW  = $clog2(MAX_PATTERNS + 1);
  localparam int SUMW  = 16 + $clog2(MAX_DIMS);
  localparam int ACCW  = QW + CNTW;
  localparam int DVW   = (SUMW > CNTW) ? SUMW : CNTW;
  localparam int ND    = QW + DVW;
  localparam int DSW   = 2 * QW + $clog2(MAX_DIMS);
  localparam int CLRS  = (MAX_PATTERNS > CENN) ? MAX_PATTERNS : CENN;
  localparam int CLRR  = (RAWN > CLRS) ? RAWN : CLRS;
  localparam int CLRW  = $clog2(CLRR + 1);

  typedef enum logic [25:0] {
    S_IDLE     = 26'd1 << 0,
    S_CLR      = 26'd1 << 1,
    S_NSUM_RD  = 26'd1 << 2,
    S_NSUM_ACC = 26'd1 << 3,
    S_NDIV_RD  = 26'd1 << 4,
    S_NDIV_GO  = 26'd1 << 5,
    S_NDIV_WT  = 26'd1 << 6,
    S_SEED_RD  = 26'd1 << 7,
    S_SEED_WR  = 26'd1 << 8,
    S_DIST_RD  = 26'd1 << 9,
    S_DIST_MUL = 26'd1 << 10,
    S_DIST_ACC = 26'd1 << 11,
    S_CMP      = 26'd1 << 12,
    S_ASG_RD   = 26'd1 << 13,
    S_ASG_WR   = 26'd1 << 14,
    S_UCLR     = 26'd1 << 15,
    S_UASG_RD  = 26'd1 << 16,
    S_UASG_CHK = 26'd1 << 17,
    S_UCNT_RD  = 26'd1 << 18,
    S_UCNT_WR  = 26'd1 << 19,
    S_USUM_RD  = 26'd1 << 20,
    S_USUM_WR  = 26'd1 << 21,
    S_MEAN_RD  = 26'd1 << 22,
    S_MEAN_GO  = 26'd1 << 23,
    S_MEAN_WT  = 26'd1 << 24,
    S_RND_END  = 26'd1 << 25
  } state_t;

  // Storage
  logic [15:0]     raw_mem [RAWN];
  logic [QW-1:0]   pat_mem [RAWN];
  logic [CLW:0]    asg_mem [MAX_PATTERNS];
  logic [QW-1:0]   cen_mem [CENN];
  logic [CNTW-1:0] cnt_mem [MAX_CLUSTERS];
  logic [ACCW-1:0] sum_mem [CENN];

  logic [15:0]     raw_q;
  logic [QW-1:0]   pat_q, cen_q;
  logic [CLW:0]    asg_q;
  logic [CNTW-1:0] cnt_q;
  logic [ACCW-1:0] sum_q;

  logic            raw_we, pat_we, asg_we, cen_we, cnt_we, sum_we;
  logic [AW-1:0]   raw_wa, pat_wa, raw_ra, pat_ra;
  logic [15:0]     raw_wd;
  logic [QW-1:0]   pat_wd, cen_wd;
  logic [PW-1:0]   asg_wa, asg_ra;
  logic [CLW:0]    asg_wd;
  logic [CAW-1:0]  cen_wa, cen_ra, sum_wa, sum_ra;
  logic [CLW-1:0]  cnt_wa, cnt_ra;
  logic [CNTW-1:0] cnt_wd;
  logic [ACCW-1:0] sum_wd;

  // Configuration
  logic [10:0] cfg_pc_r, cfg_pc_nxt;
  logic [4:0]  cfg_dc_r, cfg_dc_nxt;
  logic [4:0]  cfg_kc_r, cfg_kc_nxt;
  logic [13:0] cfg_il_r, cfg_il_nxt;

  // Sequencer
  state_t          state_r, state_nxt;
  logic [PW-1:0]   p_r, p_nxt;
  logic [CLW-1:0]  c_r, c_nxt, cl_r, cl_nxt, best_r, best_nxt;
  logic [DW-1:0]   d_r, d_nxt;
  logic [CLRW-1:0] clr_r, clr_nxt;
  logic            clr_raw_r, clr_raw_nxt;
  logic [SUMW-1:0] sum_r, sum_nxt;
  logic [DSW-1:0]  best_dist_r, best_dist_nxt;
  logic [13:0]     rounds_r, rounds_nxt, last_r, last_nxt;
  logic            change_r, change_nxt;
  logic [1:0]      q_act_r, q_act_nxt;
  logic            q_pok_r, q_pok_nxt, q_dok_r, q_dok_nxt, q_cok_r, q_cok_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_item_t       out_r, out_nxt;

  // Shared units
  logic            div_start, div_done;
  logic [ND-1:0]   div_dvd;
  logic [DVW-1:0]  div_dvs;
  logic [QW-1:0]   div_quo;
  logic            dist_clr, dist_mul, dist_acc;
  logic [DSW-1:0]  dist_sum;

  // Address and compare helpers
  logic [AW-1:0]   pd_idx, cd_idx, in_pidx;
  logic [CAW-1:0]  cen_cd, cen_ld, in_cidx;
  logic            in_pok, in_dok, in_cok, accept, cfg_ok;
  logic            d_last_dc, d_lt_dc, d_last_max, p_last, c_last, clr_last;
  logic [15:0]     mag;

  kmc_div #(.DVW(DVW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_dvd),
    .divisor(div_dvs), .done(div_done), .quotient(div_quo)
  );

  kmc_dist #(.DSW(DSW)) u_dist (
    .clk(clk), .clr(dist_clr), .mul_en(dist_mul), .acc_en(dist_acc),
    .a(pat_q), .b(cen_q), .acc(dist_sum)
  );

  always_comb begin
    pd_idx  = AW'(32'(p_r) * MAX_DIMS + 32'(d_r));
    cd_idx  = AW'(32'(c_r) * MAX_DIMS + 32'(d_r));
    in_pidx = AW'(32'(in_data.pattern_index) * MAX_DIMS + 32'(in_data.dim_index));
    cen_cd  = CAW'(32'(c_r) * MAX_DIMS + 32'(d_r));
    cen_ld  = CAW'(32'(cl_r) * MAX_DIMS + 32'(d_r));
    in_cidx = CAW'(32'(in_data.cluster_index) * MAX_DIMS + 32'(in_data.dim_index));
    in_pok  = 32'(in_data.pattern_index) < MAX_PATTERNS;
    in_dok  = 32'(in_data.dim_index) < MAX_DIMS;
    in_cok  = 32'(in_data.cluster_index) < MAX_CLUSTERS;
    d_last_dc  = 32'(d_r) == 32'(cfg_dc_r) - 32'd1;
    d_lt_dc    = 32'(d_r) < 32'(cfg_dc_r);
    d_last_max = 32'(d_r) == MAX_DIMS - 1;
    p_last     = 32'(p_r) == 32'(cfg_pc_r) - 32'd1;
    c_last     = 32'(c_r) == 32'(cfg_kc_r) - 32'd1;
    clr_last   = 32'(clr_r) == (clr_raw_r ? CLRR : CLRS) - 1;
    mag        = raw_q[15] ? 16'(17'h10000 - 17'(raw_q)) : raw_q;
    cfg_ok = cfg_pc_r >= 11'd1 && 32'(cfg_pc_r) <= MAX_PATTERNS &&
             cfg_dc_r >= 5'd1 && 32'(cfg_dc_r) <= MAX_DIMS &&
             cfg_kc_r >= 5'd1 && 32'(cfg_kc_r) <= MAX_CLUSTERS &&
             11'(cfg_kc_r) <= cfg_pc_r && cfg_il_r >= 14'd1;
  end

  assign accept    = start && !busy;
  assign busy      = state_r != S_IDLE;
  assign cfg_ready = 1'b1;

  // Pick read addresses: counters, or host fields when idle except raw and sum
  always_comb begin
    raw_ra = pd_idx;
    pat_ra = (state_r == S_IDLE) ? in_pidx :
             (state_r == S_SEED_RD || state_r == S_SEED_WR) ? cd_idx : pd_idx;
    asg_ra = (state_r == S_IDLE) ? PW'(32'(in_data.pattern_index)) : p_r;
    cen_ra = (state_r == S_IDLE) ? in_cidx : cen_cd;
    sum_ra = (state_r == S_MEAN_RD || state_r == S_MEAN_GO ||
              state_r == S_MEAN_WT) ? cen_cd : cen_ld;
    cnt_ra = (state_r == S_IDLE) ? CLW'(32'(in_data.cluster_index)) :
             (state_r == S_MEAN_RD || state_r == S_MEAN_GO ||
              state_r == S_MEAN_WT) ? c_r : cl_r;
  end

  // Sequencer next state and memory write strobes
  always_comb begin
    state_nxt     = state_r;
    p_nxt         = p_r;
    c_nxt         = c_r;
    d_nxt         = d_r;
    cl_nxt        = cl_r;
    best_nxt      = best_r;
    best_dist_nxt = best_dist_r;
    clr_nxt       = clr_r;
    clr_raw_nxt   = clr_raw_r;
    sum_nxt       = sum_r;
    rounds_nxt    = rounds_r;
    last_nxt      = last_r;
    change_nxt    = change_r;
    q_act_nxt     = q_act_r;
    q_pok_nxt     = q_pok_r;
    q_dok_nxt     = q_dok_r;
    q_cok_nxt     = q_cok_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    raw_we = 1'b0; raw_wa = pd_idx; raw_wd = '0;
    pat_we = 1'b0; pat_wa = pd_idx; pat_wd = '0;
    asg_we = 1'b0; asg_wa = p_r;    asg_wd = '0;
    cen_we = 1'b0; cen_wa = cen_cd; cen_wd = '0;
    cnt_we = 1'b0; cnt_wa = cl_r;   cnt_wd = '0;
    sum_we = 1'b0; sum_wa = cen_ld; sum_wd = '0;
    div_start = 1'b0;
    div_dvd   = ND'(mag) << 16;
    div_dvs   = DVW'(sum_r);
    dist_clr  = 1'b0;
    dist_mul  = 1'b0;
    dist_acc  = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        dist_clr = 1'b1;
        if (accept) begin
          q_act_nxt = in_data.action;
          q_pok_nxt = in_pok;
          q_dok_nxt = in_dok;
          q_cok_nxt = in_cok;
          unique case (in_data.action)
            ACT_LOAD: begin
              raw_we = in_pok && in_dok;
              raw_wa = in_pidx;
              raw_wd = in_data.raw_value;
              out_valid_nxt = 1'b1;
              out_nxt = '{status: ST_ACK, assigned_cluster: '0,
                          feature_value: '0, member_count: '0, rounds_run: last_r};
            end
            ACT_START: begin
              if (cfg_ok) begin
                state_nxt = S_NSUM_RD;
                p_nxt = '0;
                d_nxt = '0;
                sum_nxt = '0;
              end else begin
                out_valid_nxt = 1'b1;
                out_nxt = '{status: ST_BADCFG, assigned_cluster: '0,
                            feature_value: '0, member_count: '0, rounds_run: last_r};
              end
            end
            default: state_nxt = S_IDLE;
          endcase
          if (in_data.action == ACT_QPAT || in_data.action == ACT_QCEN)
            state_nxt = S_RND_END;
        end
      end

      S_CLR: begin
        raw_we = clr_raw_r && 32'(clr_r) < RAWN;
        raw_wa = AW'(clr_r);
        asg_we = 32'(clr_r) < MAX_PATTERNS;
        asg_wa = PW'(clr_r);
        cen_we = 32'(clr_r) < CENN;
        cen_wa = CAW'(clr_r);
        cnt_we = 32'(clr_r) < MAX_CLUSTERS;
        cnt_wa = CLW'(clr_r);
        clr_nxt = clr_r + CLRW'(1);
        if (clr_last) begin
          clr_nxt = '0;
          clr_raw_nxt = 1'b0;
          state_nxt = clr_raw_r ? S_IDLE : S_SEED_RD;
          c_nxt = '0;
          d_nxt = '0;
        end
      end

      // Sum of magnitudes over the used dimensions
      S_NSUM_RD: state_nxt = S_NSUM_ACC;
      S_NSUM_ACC: begin
        sum_nxt = sum_r + SUMW'(mag);
        if (d_last_dc) begin
          d_nxt = '0;
          state_nxt = S_NDIV_RD;
        end else begin
          d_nxt = d_r + DW'(1);
          state_nxt = S_NSUM_RD;
        end
      end

      // Divide each magnitude by the sum, zero beyond dim_count or for a zero sum
      S_NDIV_RD: state_nxt = S_NDIV_GO;
      S_NDIV_GO, S_NDIV_WT: begin
        if (state_r == S_NDIV_GO && d_lt_dc && sum_r != '0) begin
          div_start = 1'b1;
          state_nxt = S_NDIV_WT;
        end else if (state_r == S_NDIV_GO || div_done) begin
          pat_we = 1'b1;
          pat_wd = (state_r == S_NDIV_WT) ? div_quo : '0;
          if (d_last_max) begin
            d_nxt = '0;
            sum_nxt = '0;
            if (p_last) begin
              clr_nxt = '0;
              state_nxt = S_CLR;
            end else begin
              p_nxt = p_r + PW'(1);
              state_nxt = S_NSUM_RD;
            end
          end else begin
            d_nxt = d_r + DW'(1);
            state_nxt = S_NDIV_RD;
          end
        end
      end

      // Copy the first patterns into the centers
      S_SEED_RD: state_nxt = S_SEED_WR;
      S_SEED_WR: begin
        cen_we = 1'b1;
        cen_wd = pat_q;
        asg_we = (d_r == '0);
        asg_wa = PW'(32'(c_r));
        asg_wd = {1'b1, c_r};
        state_nxt = S_SEED_RD;
        if (d_last_dc) begin
          d_nxt = '0;
          if (c_last) begin
            c_nxt = '0;
            p_nxt = '0;
            rounds_nxt = 14'd1;
            change_nxt = 1'b0;
            state_nxt = S_DIST_RD;
          end else begin
            c_nxt = c_r + CLW'(1);
          end
        end else begin
          d_nxt = d_r + DW'(1);
        end
      end

      // Distance of one pattern to one center, one dimension at a time
      S_DIST_RD: state_nxt = S_DIST_MUL;
      S_DIST_MUL: begin
        dist_mul = 1'b1;
        state_nxt = S_DIST_ACC;
      end
      S_DIST_ACC: begin
        dist_acc = 1'b1;
        if (d_last_dc) begin
          state_nxt = S_CMP;
        end else begin
          d_nxt = d_r + DW'(1);
          state_nxt = S_DIST_RD;
        end
      end
      S_CMP: begin
        dist_clr = 1'b1;
        if (c_r == '0 || dist_sum < best_dist_r) begin
          best_nxt = c_r;
          best_dist_nxt = dist_sum;
        end
        d_nxt = '0;
        if (c_last) begin
          state_nxt = S_ASG_RD;
        end else begin
          c_nxt = c_r + CLW'(1);
          state_nxt = S_DIST_RD;
        end
      end

      // Record the nearest center and note any change
      S_ASG_RD: state_nxt = S_ASG_WR;
      S_ASG_WR: begin
        if (!asg_q[CLW] || asg_q[CLW-1:0] != best_r) begin
          asg_we = 1'b1;
          asg_wd = {1'b1, best_r};
          change_nxt = 1'b1;
        end
        c_nxt = '0;
        d_nxt = '0;
        if (p_last) begin
          clr_nxt = '0;
          state_nxt = S_UCLR;
        end else begin
          p_nxt = p_r + PW'(1);
          state_nxt = S_DIST_RD;
        end
      end

      // Clear sums and member counts before the update
      S_UCLR: begin
        sum_we = 1'b1;
        sum_wa = CAW'(clr_r);
        cnt_we = 32'(clr_r) < MAX_CLUSTERS;
        cnt_wa = CLW'(clr_r);
        clr_nxt = clr_r + CLRW'(1);
        if (32'(clr_r) == CENN - 1) begin
          clr_nxt = '0;
          p_nxt = '0;
          state_nxt = S_UASG_RD;
        end
      end

      // Accumulate each assigned pattern into its cluster
      S_UASG_RD: state_nxt = S_UASG_CHK;
      S_UASG_CHK: begin
        cl_nxt = asg_q[CLW-1:0];
        d_nxt = '0;
        if (asg_q[CLW]) begin
          state_nxt = S_UCNT_RD;
        end else if (p_last) begin
          c_nxt = '0;
          state_nxt = S_MEAN_RD;
        end else begin
          p_nxt = p_r + PW'(1);
          state_nxt = S_UASG_RD;
        end
      end
      S_UCNT_RD: state_nxt = S_UCNT_WR;
      S_UCNT_WR: begin
        cnt_we = 1'b1;
        cnt_wd = cnt_q + CNTW'(1);
        state_nxt = S_USUM_RD;
      end
      S_USUM_RD: state_nxt = S_USUM_WR;
      S_USUM_WR: begin
        sum_we = 1'b1;
        sum_wd = sum_q + ACCW'(pat_q);
        if (d_last_dc) begin
          d_nxt = '0;
          if (p_last) begin
            c_nxt = '0;
            state_nxt = S_MEAN_RD;
          end else begin
            p_nxt = p_r + PW'(1);
            state_nxt = S_UASG_RD;
          end
        end else begin
          d_nxt = d_r + DW'(1);
          state_nxt = S_USUM_RD;
        end
      end

      // Mean of each center dimension, zero for an empty cluster
      S_MEAN_RD: state_nxt = S_MEAN_GO;
      S_MEAN_GO, S_MEAN_WT: begin
        div_dvd = ND'(sum_q);
        div_dvs = DVW'(cnt_q);
        if (state_r == S_MEAN_GO && cnt_q != '0) begin
          div_start = 1'b1;
          state_nxt = S_MEAN_WT;
        end else if (state_r == S_MEAN_GO || div_done) begin
          cen_we = 1'b1;
          cen_wd = (state_r == S_MEAN_WT) ? div_quo : '0;
          state_nxt = S_MEAN_RD;
          if (d_last_dc) begin
            d_nxt = '0;
            if (c_last) begin
              state_nxt = S_RND_END;
            end else begin
              c_nxt = c_r + CLW'(1);
            end
          end else begin
            d_nxt = d_r + DW'(1);
          end
        end
      end

      // End of round, or the query read when entered from idle
      S_RND_END: begin
        state_nxt = S_IDLE;
        if (q_act_r == ACT_QPAT) begin
          out_valid_nxt = 1'b1;
          out_nxt = '{status: ST_ACK,
                      assigned_cluster: (q_pok_r && asg_q[CLW]) ?
                                        4'(asg_q[CLW-1:0]) : 4'd0,
                      feature_value: (q_pok_r && q_dok_r) ? pat_q : '0,
                      member_count: '0, rounds_run: last_r};
        end else if (q_act_r == ACT_QCEN) begin
          out_valid_nxt = 1'b1;
          out_nxt = '{status: ST_ACK, assigned_cluster: '0,
                      feature_value: (q_cok_r && q_dok_r) ? cen_q : '0,
                      member_count: q_cok_r ? 11'(cnt_q) : 11'd0,
                      rounds_run: last_r};
        end else if (change_r && rounds_r < cfg_il_r) begin
          rounds_nxt = rounds_r + 14'd1;
          change_nxt = 1'b0;
          p_nxt = '0;
          c_nxt = '0;
          d_nxt = '0;
          state_nxt = S_DIST_RD;
        end else begin
          last_nxt = rounds_r;
          out_valid_nxt = 1'b1;
          out_nxt = '{status: change_r ? ST_LIMIT : ST_CONV, assigned_cluster: '0,
                      feature_value: '0, member_count: '0, rounds_run: rounds_r};
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Configuration writes
  always_comb begin
    cfg_pc_nxt = cfg_pc_r;
    cfg_dc_nxt = cfg_dc_r;
    cfg_kc_nxt = cfg_kc_r;
    cfg_il_nxt = cfg_il_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_PATTERNS: cfg_pc_nxt = cfg_data[10:0];
        CFG_DIMS:     cfg_dc_nxt = cfg_data[4:0];
        CFG_CLUSTERS: cfg_kc_nxt = cfg_data[4:0];
        CFG_ITERS:    cfg_il_nxt = cfg_data;
        default:      cfg_il_nxt = cfg_il_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    p_r         <= p_nxt;
    c_r         <= c_nxt;
    d_r         <= d_nxt;
    cl_r        <= cl_nxt;
    best_r      <= best_nxt;
    best_dist_r <= best_dist_nxt;
    sum_r       <= sum_nxt;
    q_act_r     <= q_act_nxt;
    q_pok_r     <= q_pok_nxt;
    q_dok_r     <= q_dok_nxt;
    q_cok_r     <= q_cok_nxt;
    out_r       <= out_nxt;
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      clr_raw_r   <= 1'b1;
      rounds_r    <= '0;
      last_r      <= '0;
      change_r    <= 1'b0;
      out_valid_r <= 1'b0;
      cfg_pc_r    <= 11'd1;
      cfg_dc_r    <= 5'd1;
      cfg_kc_r    <= 5'd1;
      cfg_il_r    <= 14'd10000;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      clr_raw_r   <= clr_raw_nxt;
      rounds_r    <= rounds_nxt;
      last_r      <= last_nxt;
      change_r    <= change_nxt;
      out_valid_r <= out_valid_nxt;
      cfg_pc_r    <= cfg_pc_nxt;
      cfg_dc_r    <= cfg_dc_nxt;
      cfg_kc_r    <= cfg_kc_nxt;
      cfg_il_r    <= cfg_il_nxt;
    end
  end

  // Memory ports, registered reads
  always_ff @(posedge clk) begin
    if (raw_we) raw_mem[raw_wa] <= raw_wd;
    raw_q <= raw_mem[raw_ra];
  end

  always_ff @(posedge clk) begin
    if (pat_we) pat_mem[pat_wa] <= pat_wd;
    pat_q <= pat_mem[pat_ra];
  end

  always_ff @(posedge clk) begin
    if (asg_we) asg_mem[asg_wa] <= asg_wd;
    asg_q <= asg_mem[asg_ra];
  end

  always_ff @(posedge clk) begin
    if (cen_we) cen_mem[cen_wa] <= cen_wd;
    cen_q <= cen_mem[cen_ra];
  end

  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
    cnt_q <= cnt_mem[cnt_ra];
  end

  always_ff @(posedge clk) begin
    if (sum_we) sum_mem[sum_wa] <= sum_wd;
    sum_q <= sum_mem[sum_ra];
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

// ===== src/kmc_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
module kmc_div import kmc_pkg::*; #(
  parameter int DVW = 20
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [QW+DVW-1:0]  dividend,
  input  wire logic [DVW-1:0]     divisor,
  output logic                    done,
  output logic [QW-1:0]           quotient
);

  localparam int CW = $clog2(QW + 1);

  logic [DVW-1:0] rem_r, rem_nxt;
  logic [QW-1:0]  dvd_r, dvd_nxt;
  logic [QW-1:0]  quo_r, quo_nxt;
  logic [DVW-1:0] dvs_r, dvs_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           done_r, done_nxt;
  logic [DVW:0]   trial;
  logic           ge;

  // One restoring step per cycle, quotient bit from MSB down
  always_comb begin
    trial    = {rem_r, dvd_r[QW-1]};
    ge       = trial >= {1'b0, dvs_r};
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt = dividend[QW+DVW-1:QW];
      dvd_nxt = dividend[QW-1:0];
      dvs_nxt = divisor;
      cnt_nxt = CW'(QW);
    end else if (cnt_r != '0) begin
      rem_nxt  = ge ? DVW'(trial - {1'b0, dvs_r}) : DVW'(trial);
      dvd_nxt  = {dvd_r[QW-2:0], 1'b0};
      quo_nxt  = {quo_r[QW-2:0], ge};
      cnt_nxt  = cnt_r - CW'(1);
      done_nxt = (cnt_r == CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire

// ===== src/kmc_dist.sv =====
`timescale 1ns / 1ps
`default_nettype none
module kmc_dist import kmc_pkg::*; #(
  parameter int DSW = 38
) (
  input  wire logic          clk,
  input  wire logic          clr,
  input  wire logic          mul_en,
  input  wire logic          acc_en,
  input  wire logic [QW-1:0] a,
  input  wire logic [QW-1:0] b,
  output logic [DSW-1:0]     acc
);

  logic [2*QW-1:0] prod_r, prod_nxt;
  logic [DSW-1:0]  acc_r, acc_nxt;
  logic [QW-1:0]   diff;

  // Square the absolute difference, then add it into the distance
  always_comb begin
    diff     = (a > b) ? (a - b) : (b - a);
    prod_nxt = mul_en ? (2*QW)'(diff) * (2*QW)'(diff) : prod_r;
    acc_nxt  = acc_r;
    if (clr) acc_nxt = '0;
    else if (acc_en) acc_nxt = acc_r + DSW'(prod_r);
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
  end

  assign acc = acc_r;

endmodule
`default_nettype wire
